### sv/st_pkg.sv
// ----------------------------------------------------------------------------
// st_pkg
// Types, codes and per-byte step functions of the script tokenizer.
// ----------------------------------------------------------------------------
package st_pkg;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_SLASH = 3'd1,
    M_LINE  = 3'd2,
    M_BLOCK = 3'd3,
    M_STAR  = 3'd4,
    M_QUOTE = 3'd5,
    M_WORD  = 3'd6
  } mode_t;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3a;

  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tbyte;
    logic       quoted;
  } res_t;

  typedef struct packed {
    logic [2:0]        n;
    res_t [MaxRes-1:0] item;
    mode_t             mode;
  } step_t;

  function automatic logic is_space(logic [7:0] b);
    return (b <= CH_SPACE) || b[7];
  endfunction

  function automatic logic is_break(logic [7:0] b, logic colon);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_SQUOTE) || (colon && (b == CH_COLON));
  endfunction

  function automatic step_t push(step_t s, logic [1:0] kind, logic [7:0] b, logic q);
    step_t r;
    r = s;
    if (s.n < 3'(MaxRes)) begin
      r.item[s.n[1:0]].kind   = kind;
      r.item[s.n[1:0]].tbyte  = (kind == KIND_CHAR) ? b : CH_NUL;
      r.item[s.n[1:0]].quoted = q;
      r.n = s.n + 3'd1;
    end
    return r;
  endfunction

  function automatic step_t idle_step(step_t s, logic [7:0] b, logic colon);
    step_t r;
    r = s;
    if (b == CH_NUL) begin
      r = push(r, KIND_EOF, CH_NUL, 1'b0);
      r.mode = M_IDLE;
    end else if (is_space(b)) begin
      r.mode = M_IDLE;
    end else if (b == CH_SLASH) begin
      r.mode = M_SLASH;
    end else if (b == CH_DQUOTE) begin
      r.mode = M_QUOTE;
    end else if (is_break(b, colon)) begin
      r = push(r, KIND_CHAR, b, 1'b0);
      r = push(r, KIND_END, CH_NUL, 1'b0);
      r.mode = M_IDLE;
    end else begin
      r = push(r, KIND_CHAR, b, 1'b0);
      r.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic step_t word_step(step_t s, logic [7:0] b, logic colon);
    step_t r;
    r = s;
    if (is_break(b, colon) || is_space(b)) begin
      r = push(r, KIND_END, CH_NUL, 1'b0);
      r = idle_step(r, b, colon);
    end else begin
      r = push(r, KIND_CHAR, b, 1'b0);
      r.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic step_t do_step(mode_t mode, logic [7:0] b, logic colon);
    step_t r;
    r      = '0;
    r.mode = mode;
    case (mode)
      M_SLASH: begin
        if (b == CH_SLASH) begin
          r.mode = M_LINE;
        end else if (b == CH_STAR) begin
          r.mode = M_BLOCK;
        end else begin
          r = push(r, KIND_CHAR, CH_SLASH, 1'b0);
          r = word_step(r, b, colon);
        end
      end
      M_LINE: begin
        if (b == CH_NUL) begin
          r = push(r, KIND_EOF, CH_NUL, 1'b0);
          r.mode = M_IDLE;
        end else if (b == CH_NL) begin
          r.mode = M_IDLE;
        end
      end
      M_BLOCK, M_STAR: begin
        if (b == CH_NUL) begin
          r = push(r, KIND_EOF, CH_NUL, 1'b0);
          r.mode = M_IDLE;
        end else if ((mode == M_STAR) && (b == CH_SLASH)) begin
          r.mode = M_IDLE;
        end else begin
          r.mode = (b == CH_STAR) ? M_STAR : M_BLOCK;
        end
      end
      M_QUOTE: begin
        if (b == CH_DQUOTE) begin
          r = push(r, KIND_END, CH_NUL, 1'b1);
          r.mode = M_IDLE;
        end else if (b == CH_NUL) begin
          r = push(r, KIND_END, CH_NUL, 1'b1);
          r = push(r, KIND_EOF, CH_NUL, 1'b0);
          r.mode = M_IDLE;
        end else begin
          r = push(r, KIND_CHAR, b, 1'b1);
        end
      end
      M_WORD: begin
        r = word_step(r, b, colon);
      end
      default: begin
        r = idle_step(r, b, colon);
      end
    endcase
    return r;
  endfunction

endpackage

### sv/st_if.sv
// ----------------------------------------------------------------------------
// st_in_if / st_out_if
// Valid/ready channels for text bytes and tokenizer results.
// ----------------------------------------------------------------------------
interface st_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface st_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] token_byte;
  logic       quoted;
  logic       last;

  modport source (output valid, output kind, output token_byte, output quoted,
                  output last, input ready);
  modport sink   (input valid, input kind, input token_byte, input quoted,
                  input last, output ready);
endinterface

### sv/script_tokenizer_core.sv
// ----------------------------------------------------------------------------
// script_tokenizer_core
// Streaming tokenizer: one text byte in, zero to four result words out.
// ----------------------------------------------------------------------------
// An accepted byte is held in the first stage; its result words then go into
// the result register once that register is free. Throughput: one byte per
// cycle while each byte yields at most one result and dout.ready is high; a
// byte with several results holds the result register until all are taken.
// Reset (rst, synchronous) empties both stages, sets the mode to idle and sets
// colon_is_break to 1.
module script_tokenizer_core
  import st_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  st_in_if.sink       din,
  st_out_if.source    dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  mode_t             mode;
  logic              colon_is_break;
  logic [2:0]        grp_n;
  res_t [MaxRes-1:0] grp_item;
  logic [1:0]        idx;
  logic              grp_busy;
  logic              last_sel;
  logic              grp_free;
  logic              adv;
  logic              cfg_wr;
  step_t             step;

  assign grp_busy = (grp_n != 3'd0);
  assign last_sel = ({1'b0, idx} == (grp_n - 3'd1));
  assign grp_free = !grp_busy || (dout.ready && last_sel);
  assign adv      = s1_valid && grp_free;
  assign din.ready = !s1_valid || grp_free;

  assign step = do_step(mode, s1_byte, colon_is_break);

  assign dout.valid      = grp_busy;
  assign dout.kind       = grp_item[idx].kind;
  assign dout.token_byte = grp_item[idx].tbyte;
  assign dout.quoted     = grp_item[idx].quoted;
  assign dout.last       = last_sel;

  assign pready = 1'b1;
  assign prdata = {31'b0, colon_is_break};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      grp_n          <= 3'd0;
      idx            <= 2'd0;
      mode           <= M_IDLE;
      colon_is_break <= 1'b1;
    end else begin
      if (din.valid && din.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        grp_n <= step.n;
        idx   <= 2'd0;
        mode  <= step.mode;
      end else if (grp_busy && dout.ready) begin
        if (last_sel) begin
          grp_n <= 3'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      if (cfg_wr) begin
        colon_is_break <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_byte <= din.data_byte;
    end
    if (adv) begin
      grp_item <= step.item;
    end
  end

endmodule

### sv/st_chk.sv
// ----------------------------------------------------------------------------
// st_chk
// Port-level checks on the result channel of the script tokenizer.
// ----------------------------------------------------------------------------
module st_chk
  import st_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_token_byte,
  input logic       out_quoted,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != KIND_CHAR) |-> (out_token_byte == 8'h00))
    else $error("nonzero byte on an end word");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_EOF) |-> (out_last && !out_quoted))
    else $error("end of input word is not last or is quoted");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_CHAR || out_kind == KIND_END ||
                   out_kind == KIND_EOF))
    else $error("undefined result kind");

endmodule

bind script_tokenizer_core st_chk u_st_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_kind       (dout.kind),
  .out_token_byte (dout.token_byte),
  .out_quoted     (dout.quoted),
  .out_last       (dout.last)
);

### tb/sv/script_tokenizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_tokenizer_core_checker
// Watches the byte and result channels and the register port of the
// tokenizer, keeps its own copy of the scan mode and of the colon setting,
// works out the result words that every accepted byte must produce and
// compares each delivered word against the oldest one still waiting.
// ----------------------------------------------------------------------------
module script_tokenizer_core_checker
  import st_pkg::*;
#(
  parameter logic [2:0] ColonAddr = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  st_in_if            din,
  st_out_if           dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned errors,
  output int unsigned words_waiting,
  output int unsigned bytes_seen,
  output int unsigned words_seen
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tbyte;
    logic       quoted;
    logic       last;
  } token_word_t;

  mode_t       scan_mode = M_IDLE;
  logic        colon_brk = 1'b1;
  token_word_t expected_words[$];
  token_word_t byte_words[$];
  int unsigned err_cnt  = 0;
  int unsigned byte_cnt = 0;
  int unsigned word_cnt = 0;

  function automatic logic blank(logic [7:0] b);
    return (b <= CH_SPACE) || (b >= 8'h80);
  endfunction

  function automatic logic break_char(logic [7:0] b);
    case (b)
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE: return 1'b1;
      CH_COLON: return colon_brk;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] b, logic q);
    token_word_t w;
    w.kind   = k;
    w.tbyte  = (k == KIND_CHAR) ? b : CH_NUL;
    w.quoted = q;
    w.last   = 1'b0;
    byte_words.push_back(w);
  endfunction

  function automatic void scan_between(logic [7:0] b);
    if (b == CH_NUL) begin
      emit(KIND_EOF, CH_NUL, 1'b0);
      scan_mode = M_IDLE;
    end else if (blank(b)) begin
      scan_mode = M_IDLE;
    end else if (b == CH_SLASH) begin
      scan_mode = M_SLASH;
    end else if (b == CH_DQUOTE) begin
      scan_mode = M_QUOTE;
    end else if (break_char(b)) begin
      emit(KIND_CHAR, b, 1'b0);
      emit(KIND_END, CH_NUL, 1'b0);
      scan_mode = M_IDLE;
    end else begin
      emit(KIND_CHAR, b, 1'b0);
      scan_mode = M_WORD;
    end
  endfunction

  function automatic void scan_word(logic [7:0] b);
    if (break_char(b) || blank(b)) begin
      emit(KIND_END, CH_NUL, 1'b0);
      scan_between(b);
    end else begin
      emit(KIND_CHAR, b, 1'b0);
      scan_mode = M_WORD;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    token_word_t w;
    byte_words.delete();
    case (scan_mode)
      M_SLASH: begin
        if (b == CH_SLASH) begin
          scan_mode = M_LINE;
        end else if (b == CH_STAR) begin
          scan_mode = M_BLOCK;
        end else begin
          emit(KIND_CHAR, CH_SLASH, 1'b0);
          scan_word(b);
        end
      end
      M_LINE: begin
        if (b == CH_NUL) begin
          emit(KIND_EOF, CH_NUL, 1'b0);
          scan_mode = M_IDLE;
        end else if (b == CH_NL) begin
          scan_mode = M_IDLE;
        end
      end
      M_BLOCK, M_STAR: begin
        if (b == CH_NUL) begin
          emit(KIND_EOF, CH_NUL, 1'b0);
          scan_mode = M_IDLE;
        end else if ((scan_mode == M_STAR) && (b == CH_SLASH)) begin
          scan_mode = M_IDLE;
        end else if (b == CH_STAR) begin
          scan_mode = M_STAR;
        end else begin
          scan_mode = M_BLOCK;
        end
      end
      M_QUOTE: begin
        if (b == CH_DQUOTE) begin
          emit(KIND_END, CH_NUL, 1'b1);
          scan_mode = M_IDLE;
        end else if (b == CH_NUL) begin
          emit(KIND_END, CH_NUL, 1'b1);
          emit(KIND_EOF, CH_NUL, 1'b0);
          scan_mode = M_IDLE;
        end else begin
          emit(KIND_CHAR, b, 1'b1);
        end
      end
      M_WORD: scan_word(b);
      default: scan_between(b);
    endcase
    if (byte_words.size() > 0) begin
      w      = byte_words.pop_back();
      w.last = 1'b1;
      byte_words.push_back(w);
    end
    foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
  endfunction

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin : watch
    token_word_t want;
    if (rst) begin
      scan_mode = M_IDLE;
      colon_brk = 1'b1;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && (paddr == ColonAddr)) begin
        colon_brk = pwdata[0];
      end
      if (dout.valid && dout.ready) begin
        word_cnt++;
        if (expected_words.size() == 0) begin
          report($sformatf("word %0d arrived with nothing outstanding (kind %0d, byte %02h)",
                           word_cnt, dout.kind, dout.token_byte));
        end else begin
          want = expected_words.pop_front();
          if (dout.kind != want.kind)
            report($sformatf("word %0d kind %0d, expected %0d", word_cnt, dout.kind,
                             want.kind));
          if (dout.token_byte != want.tbyte)
            report($sformatf("word %0d token_byte %02h, expected %02h", word_cnt,
                             dout.token_byte, want.tbyte));
          if (dout.quoted != want.quoted)
            report($sformatf("word %0d quoted %0b, expected %0b", word_cnt, dout.quoted,
                             want.quoted));
          if (dout.last != want.last)
            report($sformatf("word %0d last %0b, expected %0b", word_cnt, dout.last,
                             want.last));
        end
      end
      if (din.valid && din.ready) begin
        byte_cnt++;
        predict_byte(din.data_byte);
      end
    end
    errors        <= err_cnt;
    words_waiting <= expected_words.size();
    bytes_seen    <= byte_cnt;
    words_seen    <= word_cnt;
  end

endmodule

### tb/sv/script_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_tokenizer_core_tb
// Feeds the tokenizer a short hand-picked text that touches every token
// class and corner case, then randomly composed script text with words,
// quoted strings, comments, break characters and noise, under both colon
// settings and with random gaps on both channels. The checker module judges
// every result word; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module script_tokenizer_core_tb;
  import st_pkg::*;

  localparam logic [2:0]  ADDR_COLON_IS_BREAK = 3'd0;
  localparam int unsigned RANDOM_PHASES       = 6;
  localparam int unsigned PHASE_BYTES         = 60;
  localparam int unsigned SETTLE_CYCLES       = 8;
  localparam int unsigned WATCHDOG_LIMIT      = 5000;
  localparam logic [7:0]  BREAK_CHARS [6] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN,
                                              CH_RPAREN, CH_SQUOTE, CH_COLON};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned settings_run = 0;
  int unsigned errors;
  int unsigned words_waiting;
  int unsigned bytes_seen;
  int unsigned words_seen;
  logic [7:0]  text[$];

  st_in_if  in_ch ();
  st_out_if out_ch ();

  script_tokenizer_core dut (
    .clk     (clk),
    .rst     (rst),
    .din     (in_ch),
    .dout    (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  script_tokenizer_core_checker #(
    .ColonAddr (ADDR_COLON_IS_BREAK)
  ) tok_check (
    .clk           (clk),
    .rst           (rst),
    .din           (in_ch),
    .dout          (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .words_waiting (words_waiting),
    .bytes_seen    (bytes_seen),
    .words_seen    (words_seen)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(33, 127));
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(1, 32));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] inner_byte(logic [7:0] excluded);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == excluded);
    return b;
  endfunction

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text[i]) send_byte(text[i]);
    in_ch.valid <= 1'b0;
    text.delete();
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_run++;
  endtask

  task automatic compose_text(int unsigned target);
    int unsigned pick;
    int unsigned n;
    while (text.size() < target) begin
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 6);
      if (pick < 25) begin
        repeat (n + 1) text.push_back(word_char());
        if ($urandom_range(0, 1) == 0) text.push_back(blank_byte());
      end else if (pick < 40) begin
        text.push_back(CH_DQUOTE);
        repeat (n) text.push_back(inner_byte(CH_DQUOTE));
        text.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_DQUOTE);
      end else if (pick < 52) begin
        text.push_back(BREAK_CHARS[$urandom_range(0, 5)]);
      end else if (pick < 64) begin
        repeat ((n % 3) + 1) text.push_back(blank_byte());
      end else if (pick < 72) begin
        text.push_back(CH_SLASH);
        text.push_back(CH_SLASH);
        repeat (n) text.push_back(inner_byte(CH_NL));
        text.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_NL);
      end else if (pick < 80) begin
        text.push_back(CH_SLASH);
        text.push_back(CH_STAR);
        repeat (n) text.push_back(($urandom_range(0, 2) == 0) ? CH_STAR : inner_byte(CH_STAR));
        if ($urandom_range(0, 9) == 0) begin
          text.push_back(CH_NUL);
        end else begin
          text.push_back(CH_STAR);
          text.push_back(CH_SLASH);
        end
      end else if (pick < 86) begin
        text.push_back(CH_SLASH);
        text.push_back(($urandom_range(0, 1) == 0) ? word_char() :
                       BREAK_CHARS[$urandom_range(0, 5)]);
      end else if (pick < 90) begin
        text.push_back(CH_NUL);
      end else begin
        repeat ((n % 3) + 1) text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : receiver
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
      $display("script_tokenizer_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= CH_NUL;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= ADDR_COLON_IS_BREAK;
    pwdata          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Colon is a break character out of reset.
    text = '{"a", CH_DQUOTE, "b", CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
             CH_SQUOTE, CH_COLON, CH_SLASH, "x", 8'h80, CH_SLASH, CH_LBRACE,
             CH_DQUOTE, 8'hff, CH_DQUOTE, CH_SLASH, CH_SLASH, CH_NL, CH_SLASH,
             CH_STAR, CH_STAR, CH_SLASH, CH_NUL};
    send_text();

    write_register(ADDR_COLON_IS_BREAK, 32'd0);
    text = '{"x", CH_COLON, CH_NUL, CH_DQUOTE, "q", CH_NUL};
    send_text();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_register(ADDR_COLON_IS_BREAK, {31'd0, ~p[0]});
      calm <= (p == 3);
      compose_text(PHASE_BYTES);
      send_text();
    end

    $display("Checked %0d result words from %0d text bytes", words_seen, bytes_seen);
    $display("over %0d register writes covering both colon settings.", settings_run);
    if (errors == 0) begin
      $display("script_tokenizer_core_tb: PASS");
    end else begin
      $display("script_tokenizer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/st_pkg.sv
sv/st_if.sv
sv/script_tokenizer_core.sv
sv/st_chk.sv
tb/sv/script_tokenizer_core_checker.sv
tb/sv/script_tokenizer_core_tb.sv
